@@ rtl/tprc_pkg.sv @@
// ---------------------------------------------------------------------------
// tprc_pkg
// shared types and constants of the tangent-plane rms check
// ---------------------------------------------------------------------------
package tprc_pkg;

   localparam int unsigned MAX_PAIRS_DEF = 1048576;
   localparam logic [15:0] THRESHOLD_RESET = 16'd983;   // about 0.015 in q0.16

   typedef struct packed {
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [23:0] neighbor_x;
      logic signed [23:0] neighbor_y;
      logic signed [23:0] neighbor_z;
      logic               carries_pair;
      logic               last_pair;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] rms_distance;
      logic        criterion_met;
      logic [20:0] pair_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_ACC,
      ST_CHECK,
      ST_FDIV,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/tprc_req_if.sv @@
// ---------------------------------------------------------------------------
// tprc_req_if
// valid/ready channel carrying one point, normal and neighbour item
// ---------------------------------------------------------------------------
interface tprc_req_if;
   logic                      valid;
   logic                      ready;
   tprc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tprc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// tprc_rsp_if
// valid/ready channel carrying one rms result item
// ---------------------------------------------------------------------------
interface tprc_rsp_if;
   logic                      valid;
   logic                      ready;
   tprc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tangent_plane_rms_check.sv @@
// a pair item runs the multiplier pass, divide and accumulate before the next ready, a
// terminator-only item none, a skipped pair only the multiplier pass; a last item adds the
// final divide and root (none if empty); throughput: one item at a time, set by the
// 9-step shared multiplier pass and the 26-step radix-2 divide on the shared subtractor
// reset: synchronous active high, clears sequencer, sum, count and output valid;
// threshold returns to 983
// ---------------------------------------------------------------------------
// tangent_plane_rms_check
// accumulates clamped (n.e)^2/|e|^2 ratios and reports sqrt(sum/count)
// ---------------------------------------------------------------------------
module tangent_plane_rms_check #(
   parameter int unsigned MAX_PAIRS = tprc_pkg::MAX_PAIRS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tprc_req_if.sink    req_ch,
   tprc_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // count stops at the smaller of the parameter and the field range
   localparam logic [20:0] COUNT_CAP = (MAX_PAIRS < 2097151) ? 21'(MAX_PAIRS) : 21'h1FFFFF;
   localparam logic [44:0] SUM_MAX   = '1;
   localparam logic [24:0] ONE_Q24   = 25'h1000000;

   // sequencer last-step indices
   localparam logic [5:0] MAC_LAST  = 6'd8;
   localparam logic [5:0] DIV_LAST  = 6'd25;
   localparam logic [5:0] FDIV_LAST = 6'd52;
   localparam logic [5:0] SQRT_LAST = 6'd26;

   tprc_pkg::state_type state_ff, state_in;
   logic [5:0]          step_ff, step_in;

   // item registers
   logic signed [24:0]  e_ff [3];
   logic signed [24:0]  e_in [3];
   logic signed [15:0]  n_ff [3];
   logic signed [15:0]  n_in [3];
   logic                last_ff, last_in;

   // mac accumulators
   logic [49:0]         s_ff, s_in;
   logic signed [41:0]  dp_ff, dp_in;

   // shared divide / root unit
   logic [83:0]         rem_ff, rem_in;
   logic [83:0]         dsh_ff, dsh_in;
   logic [51:0]         quot_ff, quot_in;
   logic [53:0]         root_ff, root_in;

   // running state
   logic [44:0]         sum_ff, sum_in;
   logic [20:0]         count_ff, count_in;
   logic [15:0]         thr_ff;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   tprc_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                out_free;

   // shared multiplier
   logic signed [25:0]  mul_a, mul_b;
   logic signed [51:0]  prod;
   logic [41:0]         dp_mag;
   logic [20:0]         mag_lo, mag_hi;

   // shared compare/subtract
   logic [83:0]         cmp_b;
   logic                cmp_ge;
   logic [83:0]         cmp_diff;

   logic [24:0]         ratio;
   logic [45:0]         sum_add;
   logic [15:0]         rms_sat;

   assign req_ch.ready   = (state_ff == tprc_pkg::ST_IDLE);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // magnitude of n.e split in two 21-bit halves for the squaring passes
   assign dp_mag = dp_ff[41] ? 42'(-dp_ff) : 42'(dp_ff);
   assign mag_lo = dp_mag[20:0];
   assign mag_hi = dp_mag[41:21];

   // multiplier operand select by mac step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff[3:0])
         4'd0: begin mul_a = 26'(e_ff[0]); mul_b = 26'(e_ff[0]); end
         4'd1: begin mul_a = 26'(e_ff[1]); mul_b = 26'(e_ff[1]); end
         4'd2: begin mul_a = 26'(e_ff[2]); mul_b = 26'(e_ff[2]); end
         4'd3: begin mul_a = 26'(n_ff[0]); mul_b = 26'(e_ff[0]); end
         4'd4: begin mul_a = 26'(n_ff[1]); mul_b = 26'(e_ff[1]); end
         4'd5: begin mul_a = 26'(n_ff[2]); mul_b = 26'(e_ff[2]); end
         4'd6: begin mul_a = {5'b0, mag_lo}; mul_b = {5'b0, mag_lo}; end
         4'd7: begin mul_a = {5'b0, mag_lo}; mul_b = {5'b0, mag_hi}; end
         4'd8: begin mul_a = {5'b0, mag_hi}; mul_b = {5'b0, mag_hi}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod = mul_a * mul_b;

   // root step compares against root + bit, divide steps against the shifted divisor
   assign cmp_b    = (state_ff == tprc_pkg::ST_SQRT) ? ({30'b0, root_ff} + dsh_ff) : dsh_ff;
   assign cmp_ge   = (rem_ff >= cmp_b);
   assign cmp_diff = rem_ff - cmp_b;

   // quotient above 1.0 clamps; bit 25 set means the true quotient is larger still
   assign ratio   = (quot_ff[25:0] > 26'(ONE_Q24)) ? ONE_Q24 : quot_ff[24:0];
   assign sum_add = {1'b0, sum_ff} + 46'(ratio);
   assign rms_sat = (root_ff > 54'd65535) ? 16'hFFFF : root_ff[15:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tprc_pkg::ST_IDLE: begin
            if (req_fire)
               state_in = req_ch.payload.carries_pair ? tprc_pkg::ST_MAC : tprc_pkg::ST_CHECK;
         end
         tprc_pkg::ST_MAC: begin
            if (step_ff == MAC_LAST) begin
               if (s_ff == '0 || count_ff >= COUNT_CAP)
                  state_in = tprc_pkg::ST_CHECK;
               else
                  state_in = tprc_pkg::ST_DIV;
            end
         end
         tprc_pkg::ST_DIV: begin
            if (step_ff == DIV_LAST)
               state_in = tprc_pkg::ST_ACC;
         end
         tprc_pkg::ST_ACC: state_in = tprc_pkg::ST_CHECK;
         tprc_pkg::ST_CHECK: begin
            if (!last_ff)
               state_in = tprc_pkg::ST_IDLE;
            else if (count_ff == '0)
               state_in = tprc_pkg::ST_DONE;
            else
               state_in = tprc_pkg::ST_FDIV;
         end
         tprc_pkg::ST_FDIV: begin
            if (step_ff == FDIV_LAST)
               state_in = tprc_pkg::ST_SQRT;
         end
         tprc_pkg::ST_SQRT: begin
            if (step_ff == SQRT_LAST)
               state_in = tprc_pkg::ST_DONE;
         end
         tprc_pkg::ST_DONE: begin
            if (out_free)
               state_in = tprc_pkg::ST_IDLE;
         end
         default: state_in = tprc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      step_in      = step_ff + 6'd1;
      e_in         = e_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      s_in         = s_ff;
      dp_in        = dp_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      root_in      = root_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         tprc_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_fire) begin
               // edge vector straight off the item
               e_in[0] = 25'(req_ch.payload.neighbor_x) - 25'(req_ch.payload.point_x);
               e_in[1] = 25'(req_ch.payload.neighbor_y) - 25'(req_ch.payload.point_y);
               e_in[2] = 25'(req_ch.payload.neighbor_z) - 25'(req_ch.payload.point_z);
               n_in[0] = req_ch.payload.normal_x;
               n_in[1] = req_ch.payload.normal_y;
               n_in[2] = req_ch.payload.normal_z;
               last_in = req_ch.payload.last_pair;
               s_in    = '0;
               dp_in   = '0;
            end
         end
         tprc_pkg::ST_MAC: begin
            // |e|^2, then n.e, then (n.e)^2 from three partial products
            case (step_ff[3:0])
               4'd0, 4'd1, 4'd2: s_in = s_ff + prod[49:0];
               4'd3, 4'd4, 4'd5: dp_in = dp_ff + prod[41:0];
               4'd6: rem_in = {32'b0, prod};
               4'd7: rem_in = rem_ff + {20'b0, prod[41:0], 22'b0};
               4'd8: rem_in = rem_ff + {prod[41:0], 42'b0};
               default: rem_in = rem_ff;
            endcase
            if (step_ff == MAC_LAST) begin
               step_in = '0;
               dsh_in  = {5'b0, s_ff, 29'b0};   // (|e|^2 << 4) << 25
               quot_in = '0;
            end
         end
         tprc_pkg::ST_DIV, tprc_pkg::ST_FDIV: begin
            if (cmp_ge)
               rem_in = cmp_diff;
            quot_in = {quot_ff[50:0], cmp_ge};
            dsh_in  = dsh_ff >> 1;
            if (state_ff == tprc_pkg::ST_FDIV && step_ff == FDIV_LAST) begin
               step_in = '0;
               rem_in  = {31'b0, quot_ff[51:0], cmp_ge};
               dsh_in  = 84'(1) << 52;
               root_in = '0;
            end
         end
         tprc_pkg::ST_ACC: begin
            sum_in   = sum_add[45] ? SUM_MAX : sum_add[44:0];
            count_in = count_ff + 21'd1;
         end
         tprc_pkg::ST_CHECK: begin
            step_in = '0;
            root_in = '0;
            // mean of the sum in q0.24 scaled to q0.32 for a q0.16 root
            rem_in  = {31'b0, sum_ff, 8'b0};
            dsh_in  = {11'b0, count_ff, 52'b0};
            quot_in = '0;
         end
         tprc_pkg::ST_SQRT: begin
            if (cmp_ge) begin
               rem_in  = cmp_diff;
               root_in = (root_ff >> 1) + dsh_ff[53:0];
            end else begin
               root_in = root_ff >> 1;
            end
            dsh_in = dsh_ff >> 2;
         end
         tprc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.rms_distance   = rms_sat;
               rsp_data_in.criterion_met  = (rms_sat < thr_ff);
               rsp_data_in.pair_count     = count_ff;
               sum_in                     = '0;
               count_in                   = '0;
            end
         end
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tprc_pkg::ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         thr_ff       <= tprc_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            thr_ff <= csr_wr_data;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      s_ff        <= s_in;
      dp_ff       <= dp_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // count never runs past its cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP)
      else $error("pair count above cap");

   // an accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("ready right after an accepted item");

   // an empty evaluation reports zero rms
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pair_count == '0) |-> rsp_data_ff.rms_distance == '0)
      else $error("nonzero rms with no pairs");

   // a held result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_data_ff))
      else $error("stalled result changed");
`endif

endmodule
